>>> hw/rtl/line_track_motion_sequencer_core_defines.svh
// assertion helpers for the line track sequencer
`ifndef LINE_TRACK_MOTION_SEQUENCER_CORE_DEFINES_SVH
`define LINE_TRACK_MOTION_SEQUENCER_CORE_DEFINES_SVH

// checked only outside reset
`define LTMS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define LTMS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/ltms_pkg.sv
`default_nettype none
package ltms_pkg;

  typedef logic [2:0] cmd_t;
  typedef logic [1:0] phase_t;
  typedef logic [1:0] amode_t;
  typedef logic [1:0] prerot_t;

  // drive commands
  localparam cmd_t CMD_STOP  = 3'd0;
  localparam cmd_t CMD_FWD   = 3'd1;
  localparam cmd_t CMD_LEFT  = 3'd2;
  localparam cmd_t CMD_RIGHT = 3'd3;
  localparam cmd_t CMD_CW    = 3'd4;
  localparam cmd_t CMD_CCW   = 3'd5;

  // sequencer phases
  localparam phase_t PH_SEARCH = 2'd0;
  localparam phase_t PH_ALIGN  = 2'd1;
  localparam phase_t PH_TRACK  = 2'd2;
  localparam phase_t PH_DONE   = 2'd3;

  // align modes
  localparam amode_t AM_NONE     = 2'd0;
  localparam amode_t AM_STRAIGHT = 2'd1;
  localparam amode_t AM_CW       = 2'd2;
  localparam amode_t AM_CCW      = 2'd3;

  // pre-rotation pulse codes
  localparam prerot_t PRE_NONE = 2'd0;
  localparam prerot_t PRE_CW   = 2'd1;
  localparam prerot_t PRE_CCW  = 2'd2;

  // configuration register indexes
  localparam logic REG_ARRIVAL = 1'b0;
  localparam logic REG_SPEED   = 1'b1;

  localparam logic [2:0] ARRIVAL_RESET = 3'd6;
  localparam logic [6:0] SPEED_RESET   = 7'd30;

endpackage
`default_nettype wire

>>> hw/rtl/line_track_motion_sequencer_core.sv
// channel   | ports                                    | item
// ----------+------------------------------------------+------------------------------
// input     | in_valid, in_ready, in_front/rear_black  | one sensor snapshot (tick)
// result    | out_valid, out_ready, out_*              | command, wheel speeds, flags
// config    | cfg_we, cfg_index, cfg_wdata             | register write, no wait
//
// one item per cycle sustained while out_ready is high; an accepted item passes the input
// register, then the result register, before the result channel offers it
// the sequencer state (phase, align mode, motion) updates when an item moves
// from the input register into the result register
// rst_n is synchronous: phase search, no align mode, motion stop, config defaults
// a stalled result holds the input register; in_ready drops only then
`default_nettype none
`include "line_track_motion_sequencer_core_defines.svh"

module line_track_motion_sequencer_core (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input channel
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [6:0]            in_front_black,
  input  wire logic [6:0]            in_rear_black,
  // result channel
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output ltms_pkg::prerot_t          out_pre_rotate,
  output ltms_pkg::cmd_t             out_drive_cmd,
  output logic signed [7:0]          out_wheel_a,
  output logic signed [7:0]          out_wheel_b,
  output logic signed [7:0]          out_wheel_c,
  output logic signed [7:0]          out_wheel_d,
  output logic                       out_finished,
  // configuration
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_index,
  input  wire logic [6:0]            cfg_wdata
);
  import ltms_pkg::*;

  // config registers
  logic [2:0] arrival_r;
  logic [6:0] speed_r;

  // sequencer state
  phase_t phase_r, phase_nxt;
  amode_t amode_r, amode_nxt;
  cmd_t   motion_r, motion_nxt;

  // input register
  logic       in_v_r;
  logic [6:0] front_r;
  logic [6:0] rear_r;

  // result register
  logic              out_v_r;
  prerot_t           pre_r, pre_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic signed [7:0] wa_r, wb_r, wc_r, wd_r;
  logic signed [7:0] wa_nxt, wb_nxt, wc_nxt, wd_nxt;
  logic              fin_r, fin_nxt;

  logic advance;

  // pair views and pattern flags
  logic [6:0] pb, pw;
  logic       win_narrow, win_wide;
  logic       front_white, rear_white;
  logic [2:0] front_cnt;
  logic [7:0] spd_pos, spd_neg;

  // item leaves the input register when the result register is free or draining
  assign advance  = in_v_r && (!out_v_r || out_ready);
  assign in_ready = !in_v_r || advance;

  // ---------------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arrival_r <= ARRIVAL_RESET;
      speed_r   <= SPEED_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ARRIVAL: arrival_r <= cfg_wdata[2:0];
        REG_SPEED:   speed_r   <= cfg_wdata;
        default:     ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // input register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      front_r <= in_front_black;
      rear_r  <= in_rear_black;
    end
  end

  // ---------------------------------------------------------------------------
  // pattern decode
  // pair i is front sensor i with rear sensor 18-i, i.e. front bit i-1, rear bit 7-i
  // ---------------------------------------------------------------------------
  always_comb begin
    for (int i = 0; i < 7; i++) begin
      pb[i] =  front_r[i] &&  rear_r[6-i];
      pw[i] = !front_r[i] && !rear_r[6-i];
    end
  end

  // narrow window: two black pairs inside white ones, or one or two at a row end
  assign win_narrow = (pb[0] && pw[1]) ||
                      (pb[0] && pb[1] && pw[2]) ||
                      (pw[0] && pb[1] && pb[2] && pw[3]) ||
                      (pw[1] && pb[2] && pb[3] && pw[4]) ||
                      (pw[2] && pb[3] && pb[4] && pw[5]) ||
                      (pw[3] && pb[4] && pb[5] && pw[6]) ||
                      (pw[4] && pb[5] && pb[6]) ||
                      (pw[5] && pb[6]);

  // wide band: three neighboring black pairs
  always_comb begin
    win_wide = 1'b0;
    for (int i = 0; i < 5; i++) begin
      win_wide = win_wide || (pb[i] && pb[i+1] && pb[i+2]);
    end
  end

  assign front_white = (front_r == 7'd0);
  assign rear_white  = (rear_r == 7'd0);

  always_comb begin
    front_cnt = 3'd0;
    for (int k = 0; k < 7; k++) begin
      front_cnt = front_cnt + {2'b00, front_r[k]};
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer step
  // ---------------------------------------------------------------------------
  always_comb begin
    phase_nxt  = phase_r;
    amode_nxt  = amode_r;
    motion_nxt = motion_r;
    pre_nxt    = PRE_NONE;
    fin_nxt    = 1'b0;

    // leaving align on a sensor-pair window
    if (phase_r == PH_ALIGN && win_narrow) begin
      amode_nxt = AM_NONE;
      phase_nxt = PH_TRACK;
      if (motion_r == CMD_CW) begin
        pre_nxt = PRE_CW;
      end else if (motion_r == CMD_CCW) begin
        pre_nxt = PRE_CCW;
      end
    end else if (phase_r == PH_ALIGN && win_wide) begin
      amode_nxt = AM_NONE;
      phase_nxt = PH_TRACK;
    end

    // search: slide left until a row-end pattern picks the align mode
    if (phase_nxt == PH_SEARCH) begin
      motion_nxt = CMD_LEFT;
      if (amode_nxt == AM_NONE) begin
        if (front_r[0] && rear_r[6]) begin
          amode_nxt = AM_STRAIGHT;
          phase_nxt = PH_ALIGN;
        end else if (front_white && rear_r[6]) begin
          amode_nxt = AM_CW;
          phase_nxt = PH_ALIGN;
        end else if (front_r[0] && rear_white) begin
          amode_nxt = AM_CCW;
          phase_nxt = PH_ALIGN;
        end
      end
    end

    // align
    if (phase_nxt == PH_ALIGN) begin
      case (amode_nxt)
        AM_STRAIGHT: begin
          if (front_r[3]) begin
            phase_nxt  = PH_TRACK;
            motion_nxt = CMD_FWD;
          end else begin
            motion_nxt = CMD_RIGHT;
          end
        end
        AM_CW:   motion_nxt = front_r[2] ? CMD_CW : CMD_RIGHT;
        AM_CCW:  motion_nxt = rear_r[3] ? CMD_CCW : CMD_RIGHT;
        default: ;
      endcase
    end

    // track: steer from the front row, keep motion when nothing matches
    if (phase_nxt == PH_TRACK) begin
      if (!front_r[6] && !front_r[5] && !front_r[0] && !front_r[1] &&
          front_r[2] && front_r[3] && front_r[4]) begin
        motion_nxt = CMD_FWD;
      end else if (!front_r[0] && !front_r[1] && !front_r[2] && !front_r[3] &&
                   (front_r[6] || front_r[5] || front_r[4])) begin
        motion_nxt = CMD_LEFT;
      end else if (!front_r[6] && !front_r[5] && !front_r[4] && !front_r[3] &&
                   (front_r[0] || front_r[1] || front_r[2])) begin
        motion_nxt = CMD_RIGHT;
      end
    end

    cmd_nxt = motion_nxt;

    // arrival: stop for good
    if (phase_nxt == PH_TRACK && front_cnt >= arrival_r) begin
      motion_nxt = CMD_STOP;
      phase_nxt  = PH_DONE;
      amode_nxt  = AM_NONE;
      cmd_nxt    = CMD_STOP;
      fin_nxt    = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // wheel speeds
  // ---------------------------------------------------------------------------
  assign spd_pos = {1'b0, speed_r};
  assign spd_neg = 8'd0 - spd_pos;

  always_comb begin
    wa_nxt = 8'sd0;
    wb_nxt = 8'sd0;
    wc_nxt = 8'sd0;
    wd_nxt = 8'sd0;
    case (cmd_nxt)
      CMD_FWD: begin
        wa_nxt = spd_pos; wb_nxt = spd_neg; wc_nxt = spd_neg; wd_nxt = spd_pos;
      end
      CMD_LEFT: begin
        wa_nxt = spd_neg; wb_nxt = spd_neg; wc_nxt = spd_pos; wd_nxt = spd_pos;
      end
      CMD_RIGHT: begin
        wa_nxt = spd_pos; wb_nxt = spd_pos; wc_nxt = spd_neg; wd_nxt = spd_neg;
      end
      CMD_CW: begin
        wa_nxt = spd_pos; wb_nxt = spd_pos; wc_nxt = spd_pos; wd_nxt = spd_pos;
      end
      CMD_CCW: begin
        wa_nxt = spd_neg; wb_nxt = spd_neg; wc_nxt = spd_neg; wd_nxt = spd_neg;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // state and result registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SEARCH;
      amode_r  <= AM_NONE;
      motion_r <= CMD_STOP;
    end else if (advance) begin
      phase_r  <= phase_nxt;
      amode_r  <= amode_nxt;
      motion_r <= motion_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pre_r <= pre_nxt;
      cmd_r <= cmd_nxt;
      wa_r  <= wa_nxt;
      wb_r  <= wb_nxt;
      wc_r  <= wc_nxt;
      wd_r  <= wd_nxt;
      fin_r <= fin_nxt;
    end
  end

  assign out_valid      = out_v_r;
  assign out_pre_rotate = pre_r;
  assign out_drive_cmd  = cmd_r;
  assign out_wheel_a    = wa_r;
  assign out_wheel_b    = wb_r;
  assign out_wheel_c    = wc_r;
  assign out_wheel_d    = wd_r;
  assign out_finished   = fin_r;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  `LTMS_ASSERT(a_fin_stops, (out_v_r && fin_r) |-> (cmd_r == CMD_STOP), "finished without stop")
  `LTMS_ASSERT(a_done_holds, (phase_r == PH_DONE) |=> (phase_r == PH_DONE), "left done phase")
  `LTMS_ASSERT(a_pre_after_align, (out_v_r && pre_r != PRE_NONE) |-> (phase_r == PH_TRACK || phase_r == PH_DONE), "pre-rotation outside track")
  `LTMS_ASSERT_ALWAYS(a_stall_only, !in_ready |-> (in_v_r && out_v_r && !out_ready), "input stalled without output stall")

endmodule
`default_nettype wire

>>> tb/sv/tb_top.sv
module tb_top;
  import ltms_pkg::*;

  // window classes seen by the align exit logic
  localparam logic [1:0] WIN_NONE   = 2'd0;
  localparam logic [1:0] WIN_NARROW = 2'd1;
  localparam logic [1:0] WIN_WIDE   = 2'd2;
  localparam logic [1:0] WIN_ANY    = 2'd3;

  // shaping of random front rows
  localparam int BIAS_ANY   = 0;
  localparam int BIAS_TRACK = 1;

  // ways out of the align phase
  localparam int EXIT_NARROW  = 0;
  localparam int EXIT_WIDE    = 1;
  localparam int EXIT_SENSOR4 = 2;

  // long receiver hold-off, started once after this many checked items
  localparam int HOLD_AT     = 400;
  localparam int HOLD_CYCLES = 80;

  typedef struct packed {
    logic [6:0] front;
    logic [6:0] rear;
  } snapshot_t;

  typedef struct packed {
    phase_t ph;
    amode_t am;
    cmd_t   mo;
  } seq_state_t;

  typedef struct packed {
    prerot_t           pre;
    cmd_t              cmd;
    logic signed [7:0] wa;
    logic signed [7:0] wb;
    logic signed [7:0] wc;
    logic signed [7:0] wd;
    logic              fin;
  } motion_result_t;

  typedef struct packed {
    seq_state_t     nxt;
    motion_result_t res;
  } step_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [6:0]        in_front_black = '0;
  logic [6:0]        in_rear_black = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  prerot_t           out_pre_rotate;
  cmd_t              out_drive_cmd;
  logic signed [7:0] out_wheel_a;
  logic signed [7:0] out_wheel_b;
  logic signed [7:0] out_wheel_c;
  logic signed [7:0] out_wheel_d;
  logic              out_finished;
  logic              cfg_we = 1'b0;
  logic              cfg_index = 1'b0;
  logic [6:0]        cfg_wdata = '0;

  // register copies, only changed while the block is idle
  logic [2:0] arrival_cfg = ARRIVAL_RESET;
  logic [6:0] speed_cfg = SPEED_RESET;

  // plan_st runs ahead at generation time, track_st follows accepted items
  seq_state_t plan_st = '0;
  seq_state_t track_st = '0;

  snapshot_t      snapshot_q[$];
  motion_result_t predicted_cmd_q[$];

  int  queued_total = 0;
  int  accepted_total = 0;
  int  checked_total = 0;
  int  err_count = 0;
  bit  idle_mode = 1'b1;
  int  tx_gap = 0;
  int  rx_gap = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  line_track_motion_sequencer_core u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_front_black (in_front_black),
    .in_rear_black  (in_rear_black),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pre_rotate (out_pre_rotate),
    .out_drive_cmd  (out_drive_cmd),
    .out_wheel_a    (out_wheel_a),
    .out_wheel_b    (out_wheel_b),
    .out_wheel_c    (out_wheel_c),
    .out_wheel_d    (out_wheel_d),
    .out_finished   (out_finished),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #8000000;
    $display("FAIL line_track_motion_sequencer_core");
    $finish;
  end

  // pair i joins front sensor i with rear sensor 18-i (rear bit 7-i)
  function automatic logic [1:0] window_class(input logic [6:0] f, input logic [6:0] r);
    logic [7:1] pb;
    logic [7:1] pw;
    logic       narrow;
    int         i;
    for (i = 1; i <= 7; i++) begin
      pb[i] = f[i-1] & r[7-i];
      pw[i] = ~f[i-1] & ~r[7-i];
    end
    // narrow window: two black pairs inside white ones, or one or two at a row end
    narrow = (pb[1] & pw[2]) | (pb[1] & pb[2] & pw[3]) |
             (pw[1] & pb[2] & pb[3] & pw[4]) | (pw[2] & pb[3] & pb[4] & pw[5]) |
             (pw[3] & pb[4] & pb[5] & pw[6]) | (pw[4] & pb[5] & pb[6] & pw[7]) |
             (pw[5] & pb[6] & pb[7]) | (pw[6] & pb[7]);
    if (narrow) return WIN_NARROW;
    // wide band: three black pairs in a row
    for (i = 1; i <= 5; i++)
      if (pb[i] & pb[i+1] & pb[i+2]) return WIN_WIDE;
    return WIN_NONE;
  endfunction

  // one control tick: next sequencer state and the command it issues
  function automatic step_t sequencer_step(input seq_state_t cur, input logic [6:0] f,
                                           input logic [6:0] r);
    step_t             o;
    logic [1:0]        win;
    cmd_t              cmd;
    logic signed [7:0] p;
    logic signed [7:0] n;
    int                cnt;
    int                k;
    o.nxt = cur;
    o.res = '0;
    win = window_class(f, r);

    // align left through a window, a narrow one replays the last rotation
    if (o.nxt.ph == PH_ALIGN && win == WIN_NARROW) begin
      o.nxt.am = AM_NONE;
      o.nxt.ph = PH_TRACK;
      if (o.nxt.mo == CMD_CW) o.res.pre = PRE_CW;
      else if (o.nxt.mo == CMD_CCW) o.res.pre = PRE_CCW;
    end else if (o.nxt.ph == PH_ALIGN && win == WIN_WIDE) begin
      o.nxt.am = AM_NONE;
      o.nxt.ph = PH_TRACK;
    end

    // search: slide left until a row-end pattern picks the align mode
    if (o.nxt.ph == PH_SEARCH) begin
      o.nxt.mo = CMD_LEFT;
      if (o.nxt.am == AM_NONE) begin
        if (f[0] && r[6]) begin
          o.nxt.am = AM_STRAIGHT;
          o.nxt.ph = PH_ALIGN;
        end else if (f == 7'd0 && r[6]) begin
          o.nxt.am = AM_CW;
          o.nxt.ph = PH_ALIGN;
        end else if (f[0] && r == 7'd0) begin
          o.nxt.am = AM_CCW;
          o.nxt.ph = PH_ALIGN;
        end
      end
    end

    if (o.nxt.ph == PH_ALIGN) begin
      case (o.nxt.am)
        AM_STRAIGHT: begin
          if (f[3]) begin
            o.nxt.ph = PH_TRACK;
            o.nxt.mo = CMD_FWD;
          end else begin
            o.nxt.mo = CMD_RIGHT;
          end
        end
        AM_CW: o.nxt.mo = f[2] ? CMD_CW : CMD_RIGHT;
        AM_CCW: o.nxt.mo = r[3] ? CMD_CCW : CMD_RIGHT;
        default: ;
      endcase
    end

    // track steering from the front row, no match keeps the motion
    if (o.nxt.ph == PH_TRACK) begin
      if (f == 7'b0011100) o.nxt.mo = CMD_FWD;
      else if (f[3:0] == 4'd0 && f[6:4] != 3'd0) o.nxt.mo = CMD_LEFT;
      else if (f[6:3] == 4'd0 && f[2:0] != 3'd0) o.nxt.mo = CMD_RIGHT;
    end

    cmd = o.nxt.mo;
    cnt = 0;
    for (k = 0; k < 7; k++) cnt += f[k];
    if (o.nxt.ph == PH_TRACK && cnt >= arrival_cfg) begin
      o.nxt.mo = CMD_STOP;
      o.nxt.ph = PH_DONE;
      o.nxt.am = AM_NONE;
      cmd = CMD_STOP;
      o.res.fin = 1'b1;
    end

    p = {1'b0, speed_cfg};
    n = -p;
    case (cmd)
      CMD_FWD:   {o.res.wa, o.res.wb, o.res.wc, o.res.wd} = {p, n, n, p};
      CMD_LEFT:  {o.res.wa, o.res.wb, o.res.wc, o.res.wd} = {n, n, p, p};
      CMD_RIGHT: {o.res.wa, o.res.wb, o.res.wc, o.res.wd} = {p, p, n, n};
      CMD_CW:    {o.res.wa, o.res.wb, o.res.wc, o.res.wd} = {p, p, p, p};
      CMD_CCW:   {o.res.wa, o.res.wb, o.res.wc, o.res.wd} = {n, n, n, n};
      default: begin
        cmd = CMD_STOP;
        {o.res.wa, o.res.wb, o.res.wc, o.res.wd} = '0;
      end
    endcase
    o.res.cmd = cmd;
    return o;
  endfunction

  // front rows biased toward the steering patterns when tracking
  function automatic logic [6:0] rand_front(input int bias);
    logic [31:0] u;
    logic [6:0]  f;
    u = $urandom;
    f = u[6:0];
    if (bias == BIAS_TRACK) begin
      case (u[10:8])
        3'd0: f = 7'b0011100;
        3'd1: f = {(u[13:11] == 3'd0) ? 3'd4 : u[13:11], 4'b0000};
        3'd2: f = {4'b0000, (u[13:11] == 3'd0) ? 3'd1 : u[13:11]};
        3'd3: f = f & u[17:11];
        default: ;
      endcase
    end
    return f;
  endfunction

  task automatic push_item(input logic [6:0] f, input logic [6:0] r);
    step_t     s;
    snapshot_t c;
    s = sequencer_step(plan_st, f, r);
    plan_st = s.nxt;
    c.front = f;
    c.rear = r;
    snapshot_q.push_back(c);
    queued_total++;
  endtask

  // random items with forced bits, kept only in the wanted phase and window class
  task automatic push_random(input int bias, input logic [6:0] f_set, input logic [6:0] f_keep,
                             input logic [6:0] r_set, input logic [6:0] r_keep,
                             input phase_t want_ph, input logic [1:0] want_win, input int n);
    logic [31:0] u;
    logic [6:0]  f;
    logic [6:0]  r;
    step_t       s;
    int          got;
    got = 0;
    while (got < n) begin
      u = $urandom;
      f = (rand_front(bias) & f_keep) | f_set;
      r = (u[6:0] & r_keep) | r_set;
      s = sequencer_step(plan_st, f, r);
      if (s.nxt.ph == want_ph && (want_win == WIN_ANY || window_class(f, r) == want_win)) begin
        push_item(f, r);
        got++;
      end
    end
  endtask

  // wait until every queued item has come back, then let the pipe settle
  task automatic drain();
    while (accepted_total != queued_total || predicted_cmd_q.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [6:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_ARRIVAL) arrival_cfg = val[2:0];
    else speed_cfg = val;
  endtask

  // driver: offers queued snapshots, predicts each one as it is accepted
  always @(posedge clk) begin : drive_proc
    step_t     s;
    snapshot_t c;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        s = sequencer_step(track_st, in_front_black, in_rear_black);
        track_st = s.nxt;
        predicted_cmd_q.push_back(s.res);
        accepted_total++;
      end
      // payload only moves when nothing is waiting on the port
      if (!in_valid || in_ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (snapshot_q.size() > 0) begin
          c = snapshot_q.pop_front();
          in_front_black <= c.front;
          in_rear_black <= c.rear;
          in_valid <= 1'b1;
          if (idle_mode && $urandom_range(0, 3) == 0) tx_gap = $urandom_range(1, 12);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result item against the oldest prediction
  always @(posedge clk) begin : check_proc
    motion_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_cmd_q.size() == 0) begin
          $error("result item with no prediction waiting");
          err_count++;
        end else begin
          want = predicted_cmd_q.pop_front();
          if (out_pre_rotate !== want.pre) begin
            $error("pre_rotate expected %0d actual %0d", want.pre, out_pre_rotate);
            err_count++;
          end
          if (out_drive_cmd !== want.cmd) begin
            $error("drive_cmd expected %0d actual %0d", want.cmd, out_drive_cmd);
            err_count++;
          end
          if (out_wheel_a !== want.wa) begin
            $error("wheel_a expected %0d actual %0d", $signed(want.wa), out_wheel_a);
            err_count++;
          end
          if (out_wheel_b !== want.wb) begin
            $error("wheel_b expected %0d actual %0d", $signed(want.wb), out_wheel_b);
            err_count++;
          end
          if (out_wheel_c !== want.wc) begin
            $error("wheel_c expected %0d actual %0d", $signed(want.wc), out_wheel_c);
            err_count++;
          end
          if (out_wheel_d !== want.wd) begin
            $error("wheel_d expected %0d actual %0d", $signed(want.wd), out_wheel_d);
            err_count++;
          end
          if (out_finished !== want.fin) begin
            $error("finished expected %0d actual %0d", want.fin, out_finished);
            err_count++;
          end
        end
        checked_total++;
      end
      // one long hold so the block backs up and drops in_ready
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!hold_done && checked_total >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_ready <= 1'b0;
      end else if (idle_mode && $urandom_range(0, 4) == 0) begin
        rx_gap = $urandom_range(0, 11);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // stimulus: one pass search -> align -> track -> done, config between phases
  initial begin : stim_proc
    amode_t      mode_pick;
    int          exit_kind;
    int          seg;
    logic [31:0] u;
    logic [6:0]  v;
    logic [2:0]  k;
    string       exit_name;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed search items on reset config: extremes, none of them may trigger
    push_item(7'h00, 7'h00);
    push_item(7'h7F, 7'h3F);
    push_item(7'h7E, 7'h7F);
    push_item(7'h01, 7'h3F);
    push_item(7'h40, 7'h40);
    push_item(7'h2A, 7'h55);
    push_item(7'h55, 7'h2A);
    drain();

    // search at full speed with the strictest arrival threshold
    write_reg(REG_SPEED, 7'd127);
    u = $urandom;
    v = u[6:0];
    v[2:0] = 3'd7;
    write_reg(REG_ARRIVAL, v);
    push_random(BIAS_ANY, 7'h00, 7'h7F, 7'h00, 7'h7F, PH_SEARCH, WIN_ANY, 150);
    drain();

    // zero speed
    write_reg(REG_SPEED, 7'd0);
    push_random(BIAS_ANY, 7'h00, 7'h7F, 7'h00, 7'h7F, PH_SEARCH, WIN_ANY, 50);
    drain();

    // pick the align mode through the row-end pattern
    u = $urandom_range(1, 3);
    mode_pick = u[1:0];
    u = $urandom;
    write_reg(REG_SPEED, u[6:0]);
    case (mode_pick)
      AM_STRAIGHT: push_random(BIAS_ANY, 7'h01, 7'h77, 7'h40, 7'h7F, PH_ALIGN, WIN_ANY, 1);
      AM_CW:       push_random(BIAS_ANY, 7'h00, 7'h00, 7'h40, 7'h7F, PH_ALIGN, WIN_ANY, 1);
      default:     push_random(BIAS_ANY, 7'h01, 7'h7F, 7'h00, 7'h00, PH_ALIGN, WIN_ANY, 1);
    endcase
    push_random(BIAS_ANY, 7'h00, 7'h7F, 7'h00, 7'h7F, PH_ALIGN, WIN_ANY, 150);
    drain();

    u = $urandom;
    write_reg(REG_SPEED, u[6:0]);
    push_random(BIAS_ANY, 7'h00, 7'h7F, 7'h00, 7'h7F, PH_ALIGN, WIN_ANY, 100);
    // leave CW/CCW align modes rotating so a narrow exit has something to replay
    push_random(BIAS_ANY, 7'h04, 7'h7F, 7'h08, 7'h7F, PH_ALIGN, WIN_ANY, 1);
    exit_kind = $urandom_range(0, 2);
    if (exit_kind == EXIT_SENSOR4 && mode_pick != AM_STRAIGHT) exit_kind = EXIT_NARROW;
    case (exit_kind)
      EXIT_WIDE: begin
        exit_name = "wide band";
        push_random(BIAS_ANY, 7'h00, 7'h7F, 7'h00, 7'h7F, PH_TRACK, WIN_WIDE, 1);
      end
      EXIT_SENSOR4: begin
        exit_name = "center sensor";
        push_random(BIAS_ANY, 7'h00, 7'h7F, 7'h00, 7'h7F, PH_TRACK, WIN_NONE, 1);
      end
      default: begin
        exit_name = "narrow window";
        push_random(BIAS_ANY, 7'h00, 7'h7F, 7'h00, 7'h7F, PH_TRACK, WIN_NARROW, 1);
      end
    endcase
    drain();

    // tracking segments, each below its own arrival threshold; calm at the end
    for (seg = 0; seg < 5; seg++) begin
      u = $urandom_range(2, 7);
      k = (seg == 0) ? 3'd7 : u[2:0];
      u = $urandom;
      v = u[6:0];
      v[2:0] = k;
      write_reg(REG_ARRIVAL, v);
      u = $urandom;
      write_reg(REG_SPEED, u[6:0]);
      idle_mode = (seg < 3);
      push_random(BIAS_TRACK, 7'h00, 7'h7F, 7'h00, 7'h7F, PH_TRACK, WIN_ANY, 180);
      drain();
    end

    // arrival, a zero threshold half the time, then the stopped phase
    u = $urandom_range(1, 7);
    k = ($urandom_range(0, 1) == 0) ? 3'd0 : u[2:0];
    write_reg(REG_ARRIVAL, {4'b0000, k});
    push_random(BIAS_TRACK, 7'h00, 7'h7F, 7'h00, 7'h7F, PH_DONE, WIN_ANY, 1);
    push_random(BIAS_ANY, 7'h00, 7'h7F, 7'h00, 7'h7F, PH_DONE, WIN_ANY, 40);
    drain();
    repeat (8) @(posedge clk);

    $display("summary: %0d snapshot items checked through search, align mode %0d left by %s,",
             checked_total, mode_pick, exit_name);
    $display("summary: tracking and stop at arrival threshold %0d, %0d mismatches",
             arrival_cfg, err_count);
    if (err_count == 0) begin
      $display("PASS line_track_motion_sequencer_core");
    end else begin
      $display("FAIL line_track_motion_sequencer_core");
    end
    $finish;
  end

endmodule
